>>> sv/int_to_radix_ascii_defines.svh
// assertion macros used by the int_to_radix_ascii top level
`ifndef INT_TO_RADIX_ASCII_DEFINES_SVH
`define INT_TO_RADIX_ASCII_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ITRA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ITRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/itra_pkg.sv
// types, widths and constants of the integer to ascii radix converter
package itra_pkg;

    localparam int VALUE_W     = 64;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int DIGIT_W     = 4;
    localparam int NARROW_BITS = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BASE = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

>>> sv/itra_if.sv
// request and character stream interfaces of the converter
interface itra_req_if
    import itra_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               is_signed;
    logic               is_wide;

    modport source (output valid, value, radix, is_signed, is_wide, input ready);
    modport sink   (input valid, value, radix, is_signed, is_wide, output ready);
endinterface

interface itra_rsp_if
    import itra_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   character;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, character, status, last, input ready);
    modport sink   (input valid, character, status, last, output ready);
endinterface

>>> sv/int_to_radix_ascii.sv
// top level: integer to upper-case ascii digits in base 2 to 16
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------
//  i_req    | in  | valid / ready | value[63:0] radix[4:0] is_signed is_wide
//  o_rsp    | out | valid / ready | character[7:0] status[1:0] last
//
// one request at a time; a request is taken only in idle
// each digit is one pass of the bit-serial restoring divider over all VALUE_BITS
//   dividend bits; passes repeat until the quotient is zero (up to VALUE_BITS digits)
// then a check state, a minus sign state if negative and, per digit, ram read and load
// o_rsp stalls hold the fsm in its emitting state until the output register
//   frees; the next request is taken once the last character sits in it
// synchronous active-low reset returns to idle with the output empty
module int_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_BITS  = 64,
    parameter int DIGIT_SLOTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itra_req_if.sink  i_req,
    itra_rsp_if.source o_rsp
);

`include "int_to_radix_ascii_defines.svh"

    // digit counter can hold VALUE_BITS itself; bit counter indexes one pass
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int BW = $clog2(VALUE_BITS);
    localparam int AW = $clog2(DIGIT_SLOTS);

    localparam logic [BW-1:0] BIT_LAST  = BW'(VALUE_BITS - 1);
    localparam logic [CW:0]   SLOTS_CMP = (CW + 1)'(DIGIT_SLOTS);
    localparam logic [CW:0]   BITS_CMP  = (CW + 1)'(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_FAULT,
        S_SIGN,
        S_RD,
        S_LOAD
    } t_state;

    // control
    t_state r_state, n_state;
    logic [BW-1:0] r_bit, n_bit;
    logic [CW-1:0] r_nd, n_nd;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_qnz, n_qnz;
    logic          r_o_valid, n_o_valid;

    // datapath
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic                  r_neg, n_neg;
    t_status               r_stat, n_stat;
    logic [CHAR_W-1:0]     r_o_char, n_o_char;
    t_status               r_o_stat, n_o_stat;
    logic                  r_o_last, n_o_last;

    // operand preparation
    logic [VALUE_BITS-1:0] in_lo;
    logic [VALUE_BITS-1:0] in_negated;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_sbit;
    logic                  in_neg;
    logic                  in_bad;

    // divider step
    logic [DIGIT_W:0]   trial;
    logic               qbit;
    logic [DIGIT_W-1:0] rem_step;

    // digit store
    logic               ram_we;
    logic               ram_re;
    logic [DIGIT_W-1:0] ram_rdata;
    logic [CW:0]        total;
    logic               out_free;

    assign in_lo      = i_req.is_wide ? i_req.value[VALUE_BITS-1:0]
                                      : VALUE_BITS'(i_req.value[NARROW_BITS-1:0]);
    assign in_sbit    = i_req.is_wide ? i_req.value[VALUE_BITS-1]
                                      : i_req.value[NARROW_BITS-1];
    assign in_neg     = i_req.is_signed && in_sbit;
    assign in_negated = ~in_lo + VALUE_BITS'(1);
    // most negative value negates to itself, which is the right magnitude
    assign in_mag     = !in_neg ? in_lo
                      : (i_req.is_wide ? in_negated
                                       : VALUE_BITS'(in_negated[NARROW_BITS-1:0]));
    assign in_bad     = (i_req.radix < RADIX_MIN) || (i_req.radix > RADIX_MAX);

    // restoring division, one dividend bit per cycle, quotient shifts in below
    assign trial    = {r_rem, r_mag[VALUE_BITS-1]};
    assign qbit     = (trial >= r_radix);
    assign rem_step = qbit ? DIGIT_W'(trial - r_radix) : trial[DIGIT_W-1:0];

    assign total    = {1'b0, r_nd} + (CW + 1)'(r_neg);
    assign out_free = !r_o_valid || o_rsp.ready;

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.character = r_o_char;
    assign o_rsp.status    = r_o_stat;
    assign o_rsp.last      = r_o_last;

    // digits land least significant first, read back in reverse
    itra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_SLOTS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_nd[AW-1:0]),
        .i_wdata (rem_step),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_bit     = r_bit;
        n_nd      = r_nd;
        n_idx     = r_idx;
        n_qnz     = r_qnz;
        n_mag     = r_mag;
        n_rem     = r_rem;
        n_radix   = r_radix;
        n_neg     = r_neg;
        n_stat    = r_stat;
        n_o_char  = r_o_char;
        n_o_stat  = r_o_stat;
        n_o_last  = r_o_last;
        n_o_valid = r_o_valid && !o_rsp.ready;
        ram_we    = 1'b0;
        ram_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mag   = in_mag;
                    n_radix = i_req.radix;
                    n_neg   = in_neg;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_nd    = '0;
                    n_qnz   = 1'b0;
                    if (in_bad) begin
                        n_stat  = ST_BAD_BASE;
                        n_state = S_FAULT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_mag = {r_mag[VALUE_BITS-2:0], qbit};
                n_rem = rem_step;
                n_qnz = r_qnz | qbit;
                n_bit = r_bit + BW'(1);
                if (r_bit == BIT_LAST) begin
                    // end of one pass: remainder is the next digit
                    ram_we = ({1'b0, r_nd} < SLOTS_CMP);
                    n_nd   = r_nd + CW'(1);
                    n_bit  = '0;
                    n_rem  = '0;
                    n_qnz  = 1'b0;
                    if (!(r_qnz | qbit)) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_idx = AW'(r_nd - CW'(1));
                if (total > SLOTS_CMP) begin
                    n_stat  = ST_OVERFLOW;
                    n_state = S_FAULT;
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FAULT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = CHAR_NUL;
                    n_o_stat  = r_stat;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SIGN: begin
                // at least one digit always follows the sign
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = CHAR_MINUS;
                    n_o_stat  = ST_OK;
                    n_o_last  = 1'b0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = digit_char(ram_rdata);
                    n_o_stat  = ST_OK;
                    n_o_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit     <= '0;
            r_nd      <= '0;
            r_idx     <= '0;
            r_qnz     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit     <= n_bit;
            r_nd      <= n_nd;
            r_idx     <= n_idx;
            r_qnz     <= n_qnz;
            r_o_valid <= n_o_valid;
        end
        r_mag    <= n_mag;
        r_rem    <= n_rem;
        r_radix  <= n_radix;
        r_neg    <= n_neg;
        r_stat   <= n_stat;
        r_o_char <= n_o_char;
        r_o_stat <= n_o_stat;
        r_o_last <= n_o_last;
    end

    // error results are single nul characters that close the number
    `ITRA_ASSERT_SAME(a_err_single, i_clk, i_rst_n, (r_o_valid && (r_o_stat != ST_OK)), (r_o_last && (r_o_char == CHAR_NUL)), "error result must be a last nul character")

    // partial remainder stays below the base while dividing
    `ITRA_ASSERT_SAME(a_rem_range, i_clk, i_rst_n, (r_state == S_DIV), ({1'b0, r_rem} < r_radix), "divider remainder not below radix")

    // digit count never passes the operand width
    `ITRA_ASSERT_SAME(a_nd_bound, i_clk, i_rst_n, (r_state != S_IDLE), ({1'b0, r_nd} <= BITS_CMP), "digit count beyond operand width")

    // a bad base goes straight to the fault result
    `ITRA_ASSERT_NEXT(a_bad_base, i_clk, i_rst_n, (i_req.valid && i_req.ready && in_bad), ((r_state == S_FAULT) && (r_stat == ST_BAD_BASE)), "bad base did not raise a fault")

endmodule

>>> sv/itra_ram.sv
// generic single-write, single-read ram with registered read data
module itra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> verif/tb_int_to_radix_ascii.sv
// self-checking testbench for the integer to ascii radix converter
module tb_int_to_radix_ascii;
    import itra_pkg::*;

    localparam int                MAX_REPORTS = 10;
    localparam int                DRAIN_CYCLES = 200;
    localparam int                RANDOM_PER_PHASE = 20;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;

    // one character of the output stream as the converter should send it
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        t_status           status;
        logic              last;
    } t_char_result;

    // predicts the character stream of each accepted request and checks it
    class t_digit_scoreboard;
        t_char_result expected_chars[$];
        int           fail_count;
        int           request_count;
        int           char_count;
        int           error_count;

        function new();
            fail_count    = 0;
            request_count = 0;
            char_count    = 0;
            error_count   = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_failure(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        // expected characters for one request, most significant digit first
        function void add_request(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix,
                                  bit sgn, bit wide);
            logic [VALUE_W-1:0] mask;
            logic [VALUE_W-1:0] sign_bit;
            logic [VALUE_W-1:0] magnitude;
            logic [DIGIT_W-1:0] digit;
            logic [CHAR_W-1:0]  digits[$];
            bit                 negative;
            int                 total;
            request_count++;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
                expected_chars.push_back('{CHAR_NUL, ST_BAD_BASE, 1'b1});
                return;
            end
            mask      = wide ? {VALUE_W{1'b1}} : 64'h0000_0000_FFFF_FFFF;
            sign_bit  = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
            magnitude = value & mask;
            negative  = 1'b0;
            // two's complement negate inside the operand width; the minimum
            // negates to itself, which is the right unsigned magnitude
            if (sgn && (magnitude & sign_bit) != 0) begin
                negative  = 1'b1;
                magnitude = (~magnitude + 64'd1) & mask;
            end
            if (magnitude == 0) begin
                digits.push_front(ASCII_ZERO);
            end else begin
                while (magnitude != 0) begin
                    digit = DIGIT_W'(magnitude % radix);
                    digits.push_front(CHAR_W'(digit < 10 ? ASCII_ZERO + digit
                                                         : ASCII_UPPER_A + (digit - 10)));
                    magnitude = magnitude / radix;
                end
            end
            total = digits.size() + (negative ? 1 : 0);
            if (total > 64) begin
                expected_chars.push_back('{CHAR_NUL, ST_OVERFLOW, 1'b1});
                return;
            end
            if (negative) begin
                expected_chars.push_back('{CHAR_MINUS, ST_OK, 1'b0});
            end
            foreach (digits[i]) begin
                expected_chars.push_back('{digits[i], ST_OK, i == digits.size() - 1});
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] character, logic [STATUS_W-1:0] status,
                                 logic last);
            t_char_result want;
            char_count++;
            if (status != ST_OK) begin
                error_count++;
            end
            if (expected_chars.size() == 0) begin
                note_failure($sformatf("unexpected character 0x%02h status %0d last %0b",
                                       character, status, last));
                return;
            end
            want = expected_chars.pop_front();
            if (character !== want.character || status !== want.status
                    || last !== want.last) begin
                note_failure($sformatf(
                    "char %0d: expected 0x%02h/%0d/%0b, got 0x%02h/%0d/%0b",
                    char_count, want.character, want.status, want.last,
                    character, status, last));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    itra_req_if req_if ();
    itra_rsp_if rsp_if ();

    int req_gap_pct;
    int rsp_stall_pct;

    t_digit_scoreboard sb;

    int_to_radix_ascii u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // receiver: random stalls, and every taken character goes to the scoreboard
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_char(rsp_if.character, rsp_if.status, rsp_if.last);
        end
    end

    // idle gap, then hold the request until it is taken
    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [RADIX_W-1:0] radix, input bit sgn, input bit wide);
        while ($urandom_range(99) < req_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.value     <= value;
        req_if.radix     <= radix;
        req_if.is_signed <= sgn;
        req_if.is_wide   <= wide;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        sb.add_request(value, radix, sgn, wide);
    endtask

    // mixes full-width noise with small, negative and power-of-two operands
    task automatic send_random_request();
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        case ($urandom_range(4))
            0: value = {$urandom, $urandom};
            1: value = 64'($urandom_range(1000));
            2: value = -64'($urandom_range(1000));
            3: value = 64'd1 << $urandom_range(63);
            default: value = -(64'd1 << $urandom_range(63));
        endcase
        // mostly legal bases; the rest sweeps the whole radix field
        radix = ($urandom_range(9) != 0) ? RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX))
                                         : RADIX_W'($urandom_range(31));
        send_request(value, radix, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial begin
        sb            = new();
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.value     <= '0;
        req_if.radix     <= '0;
        req_if.is_signed <= 1'b0;
        req_if.is_wide   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // illegal bases: one error character each, whatever the value
        send_request(64'd123, 5'd0, 1'b0, 1'b0);
        send_request(64'd123, 5'd1, 1'b1, 1'b1);
        send_request(64'd123, 5'd17, 1'b0, 1'b1);
        send_request('1, 5'd31, 1'b1, 1'b0);
        // zero gives a lone digit in any base
        send_request(64'd0, 5'd16, 1'b0, 1'b1);
        send_request(64'd0, 5'd2, 1'b1, 1'b0);
        // signed 64-bit minimum in base 2 needs 65 characters
        send_request(64'h8000_0000_0000_0000, 5'd2, 1'b1, 1'b1);
        // longest legal output: 64 ones
        send_request('1, 5'd2, 1'b0, 1'b1);
        send_request(64'h8000_0000_0000_0001, 5'd2, 1'b1, 1'b1);
        // most negative values of both widths
        send_request(64'h8000_0000_0000_0000, 5'd10, 1'b1, 1'b1);
        send_request(64'h0000_0000_8000_0000, 5'd10, 1'b1, 1'b0);
        send_request(64'h0000_0000_8000_0000, 5'd2, 1'b1, 1'b0);
        // upper bits ignored in narrow mode
        send_request(64'hDEAD_BEEF_FFFF_FFFF, 5'd10, 1'b0, 1'b0);
        send_request(64'hDEAD_BEEF_FFFF_FFFF, 5'd16, 1'b1, 1'b0);
        send_request(64'hFFFF_FFFF_7FFF_FFFF, 5'd10, 1'b1, 1'b0);
        // wide extremes and minus one
        send_request('1, 5'd16, 1'b0, 1'b1);
        send_request('1, 5'd10, 1'b1, 1'b1);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, 5'd3, 1'b1, 1'b1);
        send_request(64'd255, 5'd15, 1'b0, 1'b1);
        send_request(64'd1_000_000, 5'd7, 1'b0, 1'b0);
        send_request(64'h0123_4567_89AB_CDEF, 5'd16, 1'b0, 1'b1);

        // random traffic under four pressure profiles
        for (int phase = 0; phase < 4; phase++) begin
            req_gap_pct   = (phase == 1) ? 86 : (phase == 3) ? 6 : 0;
            rsp_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 6 : 0;
            repeat (RANDOM_PER_PHASE) send_random_request();
        end
        req_if.valid <= 1'b0;

        // let the output stream drain, then catch any stray characters
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d characters (%0d error statuses)",
                 sb.request_count, sb.char_count, sb.error_count);
        $display("pressure: none, sender gaps, receiver stalls, then light mixed idling");
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout with %0d characters outstanding", sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
